// ----- rtl/nad_pkg.sv -----
// shared constants and the cordic angle table of the needle arc distance unit
// no dependencies; used by every other file of the block
package nad_pkg;

	localparam int COORD_W      = 32;
	localparam int QUAT_W       = 18;
	localparam int ARC_W        = 40;
	localparam int IN_W         = 6 * COORD_W + 4 * QUAT_W;
	localparam int FRAC_BITS_DEF = 16;
	localparam int RAD_W        = 64;
	localparam int ROOT_W       = 32;
	localparam int DIV_W        = 64;
	localparam int CORDIC_STEPS = 30;
	localparam int ANG_W        = 32;
	localparam logic [ARC_W-1:0] ARC_MAX = '1;

	// atan(2^-i) in q.30 radians
	function automatic logic signed [ANG_W-1:0] atan_step(input int idx);
		logic signed [ANG_W-1:0] res;
		case (idx)
			0:       res = 32'sd843314857;
			1:       res = 32'sd497837829;
			2:       res = 32'sd263043837;
			3:       res = 32'sd133525159;
			4:       res = 32'sd67021687;
			5:       res = 32'sd33543516;
			6:       res = 32'sd16775851;
			7:       res = 32'sd8388437;
			8:       res = 32'sd4194283;
			9:       res = 32'sd2097149;
			10:      res = 32'sd1048576;
			default: res = 32'sd1 <<< (30 - idx);
		endcase
		return res;
	endfunction

endpackage

// ----- rtl/nad_isqrt.sv -----
// pipelined integer square root, one result bit per stage
// depends on nad_pkg
module nad_isqrt #(
	parameter int PASS_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [nad_pkg::RAD_W-1:0]   in_rad,
	input  logic [PASS_W-1:0]           in_pass,
	output logic                        out_valid,
	output logic [nad_pkg::ROOT_W-1:0]  out_root,
	output logic [PASS_W-1:0]           out_pass
);

	localparam int N   = nad_pkg::ROOT_W;
	localparam int R_W = N + 3;

	logic                        vld  [0:N];
	logic [nad_pkg::RAD_W-1:0]   rad  [0:N];
	logic [R_W-1:0]              rem  [0:N];
	logic [N-1:0]                root [0:N];
	logic [PASS_W-1:0]           pass [0:N];

	assign vld[0]  = in_valid;
	assign rad[0]  = in_rad;
	assign rem[0]  = '0;
	assign root[0] = '0;
	assign pass[0] = in_pass;

	for (genvar j = 0; j < N; j++) begin : g_stage
		logic [R_W-1:0] sh;
		logic [R_W-1:0] trial;
		logic           ge;

		assign sh    = {rem[j][R_W-3:0], rad[j][nad_pkg::RAD_W-1-2*j -: 2]};
		assign trial = {1'b0, root[j], 2'b01};
		assign ge    = (sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[j+1] <= 1'b0;
			end else if (en) begin
				vld[j+1] <= vld[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad[j+1]  <= rad[j];
				rem[j+1]  <= ge ? (sh - trial) : sh;
				root[j+1] <= {root[j][N-2:0], ge};
				pass[j+1] <= pass[j];
			end
		end
	end

	assign out_valid = vld[N];
	assign out_root  = root[N];
	assign out_pass  = pass[N];

endmodule

// ----- rtl/nad_div_atan.sv -----
// pipelined restoring divider with a cordic vectoring unit in its first stages
// depends on nad_pkg
module nad_div_atan #(
	parameter int PASS_W = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [nad_pkg::DIV_W-1:0]         in_dividend,
	input  logic [nad_pkg::ROOT_W-1:0]        in_root,
	input  logic [nad_pkg::ROOT_W-2:0]        in_c,
	input  logic [PASS_W-1:0]                 in_pass,
	output logic                              out_valid,
	output logic [nad_pkg::DIV_W-1:0]         out_quo,
	output logic signed [nad_pkg::ANG_W-1:0]  out_phi,
	output logic [PASS_W-1:0]                 out_pass
);

	localparam int N    = nad_pkg::DIV_W;
	localparam int DV_W = nad_pkg::ROOT_W + 1;
	localparam int CV_W = nad_pkg::ROOT_W + 4;

	logic                               vld  [0:N];
	logic [N-1:0]                       num  [0:N];
	logic [DV_W-1:0]                    dv   [0:N];
	logic [DV_W-1:0]                    rem  [0:N];
	logic [N-1:0]                       quo  [0:N];
	logic signed [CV_W-1:0]             xv   [0:N];
	logic signed [CV_W-1:0]             yv   [0:N];
	logic signed [nad_pkg::ANG_W-1:0]   acc  [0:N];
	logic [PASS_W-1:0]                  pass [0:N];

	assign vld[0]  = in_valid;
	assign num[0]  = in_dividend;
	assign dv[0]   = {in_root, 1'b0};
	assign rem[0]  = '0;
	assign quo[0]  = '0;
	assign xv[0]   = $signed(CV_W'(in_c));
	assign yv[0]   = $signed(CV_W'(in_root));
	assign acc[0]  = '0;
	assign pass[0] = in_pass;

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [DV_W:0]          sh;
		logic                   ge;
		logic signed [CV_W-1:0] xv_n;
		logic signed [CV_W-1:0] yv_n;
		logic signed [nad_pkg::ANG_W-1:0] acc_n;

		assign sh = {rem[i], num[i][N-1-i]};
		assign ge = (sh >= {1'b0, dv[i]});

		if (i < nad_pkg::CORDIC_STEPS) begin : g_rot
			localparam logic signed [nad_pkg::ANG_W-1:0] ANG = nad_pkg::atan_step(i);
			logic signed [CV_W-1:0] dx;
			logic signed [CV_W-1:0] dy;

			assign dx = yv[i] >>> i;
			assign dy = xv[i] >>> i;

			always_comb begin
				if (yv[i] > 0) begin
					xv_n  = xv[i] + dx;
					yv_n  = yv[i] - dy;
					acc_n = acc[i] + ANG;
				end else begin
					xv_n  = xv[i] - dx;
					yv_n  = yv[i] + dy;
					acc_n = acc[i] - ANG;
				end
			end
		end else begin : g_hold
			assign xv_n  = xv[i];
			assign yv_n  = yv[i];
			assign acc_n = acc[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[i+1] <= 1'b0;
			end else if (en) begin
				vld[i+1] <= vld[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num[i+1]  <= num[i];
				dv[i+1]   <= dv[i];
				rem[i+1]  <= ge ? DV_W'(sh - {1'b0, dv[i]}) : DV_W'(sh);
				quo[i+1]  <= {quo[i][N-2:0], ge};
				xv[i+1]   <= xv_n;
				yv[i+1]   <= yv_n;
				acc[i+1]  <= acc_n;
				pass[i+1] <= pass[i];
			end
		end
	end

	assign out_valid = vld[N];
	assign out_quo   = quo[N];
	assign out_phi   = acc[N];
	assign out_pass  = pass[N];

endmodule

// ----- rtl/needle_arc_distance.sv -----
// needle arc distance unit, top level
// depends on nad_pkg, nad_isqrt and nad_div_atan

// Takes one request per cycle: a tip point and a frame pose (origin plus
// quaternion, not normalized). The tip is projected into the frame through the
// rotation matrix of the quaternion, a tip behind the frame or one whose arc
// radius falls below min_radius comes back with unreachable set and a zero
// distance, a tip with no lateral offset gets its z distance, otherwise the arc
// length r * 2 * atan2(x, z); both unsigned q24.16, saturating. Throughput is
// one request per clock. The pipe has seven stages of projection, scaling and
// squaring, 32 stages of square root (one root bit each), two stages of radius
// numerator, 64 stages of division (one quotient bit each, with the 30 cordic
// rotations riding along in the first of them) and three stages of final
// multiply and selection. The whole pipe holds while the output register is
// full and not taken. min_radius may only be written while the unit is empty.
module needle_arc_distance #(
	parameter int FRAC_BITS = nad_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_wr_en,
	input  logic [31:0]                 cfg_wr_data,   // min_radius
	// request side
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// tip_x, tip_y, tip_z, frame_x, frame_y, frame_z, quat_w, quat_i, quat_j, quat_k
	input  logic [nad_pkg::IN_W-1:0]    s_axis_tdata,
	// result side
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [nad_pkg::ARC_W-1:0]   m_axis_tdata,  // arc_length
	output logic                        m_axis_tuser   // unreachable
);

	localparam int CW    = nad_pkg::COORD_W;
	localparam int QW    = nad_pkg::QUAT_W;
	localparam int QQ_W  = 2 * QW;
	// rotation entries at double fraction, then rounded to single fraction
	localparam int RM_W  = ((2 * FRAC_BITS + 2 > 38) ? 2 * FRAC_BITS + 2 : 38) + 1;
	localparam int RR_W  = RM_W - FRAC_BITS + 2;
	localparam int D_W   = CW + 1;
	localparam int RD_W  = RR_W + D_W;
	localparam int PS_W  = RD_W + 2;
	localparam int PM_W  = PS_W + 1 - FRAC_BITS;
	localparam int K_W   = $clog2(PM_W - 30);
	localparam int SW    = nad_pkg::ROOT_W - 1;  // width of scaled a, b, c
	localparam int AW    = nad_pkg::ARC_W;
	localparam int SIDE_W = 1 + K_W + AW;
	localparam int SQP_W = SW + SIDE_W;
	localparam int DVP_W = 1 + SIDE_W;
	localparam logic signed [RM_W-1:0] ONE_RM = RM_W'(1) <<< (2 * FRAC_BITS);
	localparam logic [RM_W:0]  HALF_RM = (RM_W+1)'(1) << (FRAC_BITS - 1);
	localparam logic [PS_W:0]  HALF_PS = (PS_W+1)'(1) << (FRAC_BITS - 1);

	// round half away from zero, signed result
	function automatic logic signed [RR_W-1:0] rnd_rm(input logic signed [RM_W-1:0] v);
		logic signed [RM_W:0] sv;
		logic [RM_W:0]        mag;
		logic [RM_W:0]        t;
		sv  = (RM_W+1)'(v);
		mag = sv[RM_W] ? $unsigned(-sv) : $unsigned(sv);
		t   = (mag + HALF_RM) >> FRAC_BITS;
		return sv[RM_W] ? -$signed(RR_W'(t)) : $signed(RR_W'(t));
	endfunction

	// round half away from zero, magnitude only
	function automatic logic [PM_W-1:0] rnd_mag(input logic signed [PS_W-1:0] v);
		logic signed [PS_W:0] sv;
		logic [PS_W:0]        mag;
		logic [PS_W:0]        t;
		sv  = (PS_W+1)'(v);
		mag = sv[PS_W] ? $unsigned(-sv) : $unsigned(sv);
		t   = (mag + HALF_PS) >> FRAC_BITS;
		return PM_W'(t);
	endfunction

	logic en;
	logic v_s12;

	// the whole pipe advances unless the output holds an untaken result
	assign en            = !v_s12 || m_axis_tready;
	assign s_axis_tready = en;

	// configuration register
	logic [31:0] min_radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_radius_q <= '0;
		end else if (cfg_wr_en) begin
			min_radius_q <= cfg_wr_data;
		end
	end

	// field unpacking
	logic signed [CW-1:0] tip_x, tip_y, tip_z, frame_x, frame_y, frame_z;
	logic signed [QW-1:0] quat_w, quat_i, quat_j, quat_k;

	assign tip_x   = $signed(s_axis_tdata[0*CW +: CW]);
	assign tip_y   = $signed(s_axis_tdata[1*CW +: CW]);
	assign tip_z   = $signed(s_axis_tdata[2*CW +: CW]);
	assign frame_x = $signed(s_axis_tdata[3*CW +: CW]);
	assign frame_y = $signed(s_axis_tdata[4*CW +: CW]);
	assign frame_z = $signed(s_axis_tdata[5*CW +: CW]);
	assign quat_w  = $signed(s_axis_tdata[6*CW +: QW]);
	assign quat_i  = $signed(s_axis_tdata[6*CW+QW +: QW]);
	assign quat_j  = $signed(s_axis_tdata[6*CW+2*QW +: QW]);
	assign quat_k  = $signed(s_axis_tdata[6*CW+3*QW +: QW]);

	// s1: offset from the frame origin and quaternion products
	logic                   v_s1;
	logic signed [D_W-1:0]  d_s1 [3];
	logic signed [QQ_W-1:0] ii_s1, jj_s1, kk_s1, ij_s1, wk_s1, ik_s1, wj_s1, jk_s1, wi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= D_W'(tip_x) - D_W'(frame_x);
			d_s1[1] <= D_W'(tip_y) - D_W'(frame_y);
			d_s1[2] <= D_W'(tip_z) - D_W'(frame_z);
			ii_s1   <= quat_i * quat_i;
			jj_s1   <= quat_j * quat_j;
			kk_s1   <= quat_k * quat_k;
			ij_s1   <= quat_i * quat_j;
			wk_s1   <= quat_w * quat_k;
			ik_s1   <= quat_i * quat_k;
			wj_s1   <= quat_w * quat_j;
			jk_s1   <= quat_j * quat_k;
			wi_s1   <= quat_w * quat_i;
		end
	end

	// s2: rotation matrix, rounded to single fraction
	logic                   v_s2;
	logic signed [D_W-1:0]  d_s2 [3];
	logic signed [RR_W-1:0] r_s2 [3][3];
	logic signed [RM_W-1:0] rm_c [3][3];

	always_comb begin
		rm_c[0][0] = ONE_RM - ((RM_W'(jj_s1) + RM_W'(kk_s1)) <<< 1);
		rm_c[0][1] = (RM_W'(ij_s1) - RM_W'(wk_s1)) <<< 1;
		rm_c[0][2] = (RM_W'(ik_s1) + RM_W'(wj_s1)) <<< 1;
		rm_c[1][0] = (RM_W'(ij_s1) + RM_W'(wk_s1)) <<< 1;
		rm_c[1][1] = ONE_RM - ((RM_W'(ii_s1) + RM_W'(kk_s1)) <<< 1);
		rm_c[1][2] = (RM_W'(jk_s1) - RM_W'(wi_s1)) <<< 1;
		rm_c[2][0] = (RM_W'(ik_s1) - RM_W'(wj_s1)) <<< 1;
		rm_c[2][1] = (RM_W'(jk_s1) + RM_W'(wi_s1)) <<< 1;
		rm_c[2][2] = ONE_RM - ((RM_W'(ii_s1) + RM_W'(jj_s1)) <<< 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2 <= d_s1;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					r_s2[r][c] <= rnd_rm(rm_c[r][c]);
				end
			end
		end
	end

	// s3: transposed rotation products, column c of p takes row r times d[r]
	logic                   v_s3;
	logic signed [RD_W-1:0] pr_s3 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					pr_s3[r][c] <= RD_W'(r_s2[r][c]) * RD_W'(d_s2[r]);
				end
			end
		end
	end

	// s4: projected point as magnitudes, behind flag from the sign of z
	logic                   v_s4;
	logic [PM_W-1:0]        a_s4, b_s4, c_s4;
	logic                   behind_s4;
	logic signed [PS_W-1:0] ps_c [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			ps_c[c] = PS_W'(pr_s3[0][c]) + PS_W'(pr_s3[1][c]) + PS_W'(pr_s3[2][c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s4      <= rnd_mag(ps_c[0]);
			b_s4      <= rnd_mag(ps_c[1]);
			c_s4      <= rnd_mag(ps_c[2]);
			// a negative sum that rounds to zero is not behind
			behind_s4 <= ps_c[2][PS_W-1] && (rnd_mag(ps_c[2]) != '0);
		end
	end

	// s5: common scaling so that a, b and c fit in 31 bits
	logic            v_s5;
	logic [SW-1:0]   a_s5, b_s5, c_s5;
	logic [K_W-1:0]  k_s5;
	logic [AW-1:0]   csat_s5;
	logic            behind_s5;
	logic [PM_W-1:0] or_c;
	logic [K_W-1:0]  k_c;
	logic [PM_W-1:0] as_c, bs_c, cs_c;

	always_comb begin
		or_c = a_s4 | b_s4 | c_s4;
		k_c  = '0;
		for (int i = SW; i < PM_W; i++) begin
			if (or_c[i]) begin
				k_c = K_W'(i - SW + 1);
			end
		end
		as_c = a_s4 >> k_c;
		bs_c = b_s4 >> k_c;
		cs_c = c_s4 >> k_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s5      <= as_c[SW-1:0];
			b_s5      <= bs_c[SW-1:0];
			c_s5      <= cs_c[SW-1:0];
			k_s5      <= k_c;
			// distance used when there is no lateral offset
			csat_s5   <= ((c_s4 >> AW) != '0) ? nad_pkg::ARC_MAX : c_s4[AW-1:0];
			behind_s5 <= behind_s4;
		end
	end

	// s6: squares of the lateral offsets
	logic              v_s6;
	logic [2*SW-1:0]   aa_s6, bb_s6;
	logic [SW-1:0]     c_s6;
	logic [SIDE_W-1:0] side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			aa_s6   <= a_s5 * a_s5;
			bb_s6   <= b_s5 * b_s5;
			c_s6    <= c_s5;
			side_s6 <= {behind_s5, k_s5, csat_s5};
		end
	end

	// s7: radicand
	logic                      v_s7;
	logic [nad_pkg::RAD_W-1:0] rad_s7;
	logic [SQP_W-1:0]          sqp_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s7 <= nad_pkg::RAD_W'(aa_s6) + nad_pkg::RAD_W'(bb_s6);
			sqp_s7 <= {c_s6, side_s6};
		end
	end

	// lateral offset x = floor(sqrt(a^2 + b^2))
	logic                       v_sq;
	logic [nad_pkg::ROOT_W-1:0] xs_sq;
	logic [SQP_W-1:0]           sqp_sq;

	nad_isqrt #(
		.PASS_W (SQP_W)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.in_rad    (rad_s7),
		.in_pass   (sqp_s7),
		.out_valid (v_sq),
		.out_root  (xs_sq),
		.out_pass  (sqp_sq)
	);

	// s8: squares for the radius numerator
	logic                         v_s8;
	logic [2*nad_pkg::ROOT_W-1:0] xx_s8;
	logic [2*SW-1:0]              cc_s8;
	logic [nad_pkg::ROOT_W-1:0]   xs_s8;
	logic [SW-1:0]                c_s8;
	logic [SIDE_W-1:0]            side_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_sq;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s8   <= xs_sq * xs_sq;
			cc_s8   <= sqp_sq[SQP_W-1 -: SW] * sqp_sq[SQP_W-1 -: SW];
			xs_s8   <= xs_sq;
			c_s8    <= sqp_sq[SQP_W-1 -: SW];
			side_s8 <= sqp_sq[SIDE_W-1:0];
		end
	end

	// s9: radius numerator x^2 + c^2
	logic                       v_s9;
	logic [nad_pkg::DIV_W-1:0]  num_s9;
	logic [nad_pkg::ROOT_W-1:0] xs_s9;
	logic [SW-1:0]              c_s9;
	logic [DVP_W-1:0]           dvp_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s9 <= nad_pkg::DIV_W'(xx_s8) + nad_pkg::DIV_W'(cc_s8);
			xs_s9  <= xs_s8;
			c_s9   <= c_s8;
			dvp_s9 <= {(xs_s8 == '0), side_s8};
		end
	end

	// radius = num / (2x) and half angle = atan2(x, c)
	logic                             v_dv;
	logic [nad_pkg::DIV_W-1:0]        rq_dv;
	logic signed [nad_pkg::ANG_W-1:0] phi_dv;
	logic [DVP_W-1:0]                 dvp_dv;

	nad_div_atan #(
		.PASS_W (DVP_W)
	) u_div_atan (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (v_s9),
		.in_dividend (num_s9),
		.in_root     (xs_s9),
		.in_c        (c_s9),
		.in_pass     (dvp_s9),
		.out_valid   (v_dv),
		.out_quo     (rq_dv),
		.out_phi     (phi_dv),
		.out_pass    (dvp_dv)
	);

	// s10: split radius times angle, minimum radius check
	logic                     v_s10;
	logic [SW+nad_pkg::ANG_W-1:0] plo_s10, phi_s10;
	logic                     small_s10;
	logic                     xz_s10;
	logic [SIDE_W-1:0]        side_s10;
	logic [K_W-1:0]           k_dv;
	logic [32:0]              thr_c;
	logic [nad_pkg::ANG_W-1:0] theta_c;

	assign k_dv    = dvp_dv[AW +: K_W];
	// threshold scaled down with rounding up, so it compares against the scaled radius
	assign thr_c   = ({1'b0, min_radius_q} + ((33'd1 << k_dv) - 33'd1)) >> k_dv;
	// theta = 2 * phi, negative angles clamp to zero
	assign theta_c = phi_dv[nad_pkg::ANG_W-1] ? '0 : {phi_dv[nad_pkg::ANG_W-2:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= v_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s10   <= rq_dv[SW-1:0] * theta_c;
			phi_s10   <= rq_dv[2*SW-1:SW] * theta_c;
			small_s10 <= (rq_dv < nad_pkg::DIV_W'(thr_c));
			xz_s10    <= dvp_dv[DVP_W-1];
			side_s10  <= dvp_dv[SIDE_W-1:0];
		end
	end

	// s11: recombine and drop 30 fraction bits of the angle
	localparam int FULL_W = 2 * SW + nad_pkg::ANG_W;
	logic              v_s11;
	logic [63:0]       prod_s11;
	logic              small_s11;
	logic              xz_s11;
	logic [SIDE_W-1:0] side_s11;
	logic [FULL_W-1:0] full_c;

	assign full_c = (FULL_W'(phi_s10) << SW) + FULL_W'(plo_s10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s11  <= full_c[93:30];
			small_s11 <= small_s10;
			xz_s11    <= xz_s10;
			side_s11  <= side_s10;
		end
	end

	// s12: output register, rescale, saturate and pick the special cases
	logic           behind_c;
	logic [K_W-1:0] k_c11;
	logic [AW-1:0]  csat_c;
	logic [AW-1:0]  lim_c;
	logic [63:0]    shifted_c;
	logic [AW-1:0]  arc_c;
	logic           unr_c;
	logic [AW-1:0]  arc_s12;
	logic           unr_s12;

	assign behind_c  = side_s11[SIDE_W-1];
	assign k_c11     = side_s11[AW +: K_W];
	assign csat_c    = side_s11[AW-1:0];
	assign lim_c     = nad_pkg::ARC_MAX >> k_c11;
	assign shifted_c = prod_s11 << k_c11;

	always_comb begin
		if (behind_c) begin
			arc_c = '0;
			unr_c = 1'b1;
		end else if (xz_s11) begin
			arc_c = csat_c;
			unr_c = 1'b0;
		end else if (small_s11) begin
			arc_c = '0;
			unr_c = 1'b1;
		end else if (prod_s11 > 64'(lim_c)) begin
			arc_c = nad_pkg::ARC_MAX;
			unr_c = 1'b0;
		end else begin
			arc_c = shifted_c[AW-1:0];
			unr_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			arc_s12 <= arc_c;
			unr_s12 <= unr_c;
		end
	end

	assign m_axis_tvalid = v_s12;
	assign m_axis_tdata  = arc_s12;
	assign m_axis_tuser  = unr_s12;

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking bench for needle_arc_distance: directed table, then random pose requests
// depends on nad_pkg and the needle_arc_distance rtl; results checked against a local predictor
module testbench;

	localparam int FB = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT = 150;
	localparam int RANDOM_ITEMS = 900;

	// one request, first field in the lowest bits
	typedef struct packed {
		logic signed [nad_pkg::QUAT_W-1:0]  quat_k;
		logic signed [nad_pkg::QUAT_W-1:0]  quat_j;
		logic signed [nad_pkg::QUAT_W-1:0]  quat_i;
		logic signed [nad_pkg::QUAT_W-1:0]  quat_w;
		logic signed [nad_pkg::COORD_W-1:0] frame_z;
		logic signed [nad_pkg::COORD_W-1:0] frame_y;
		logic signed [nad_pkg::COORD_W-1:0] frame_x;
		logic signed [nad_pkg::COORD_W-1:0] tip_z;
		logic signed [nad_pkg::COORD_W-1:0] tip_y;
		logic signed [nad_pkg::COORD_W-1:0] tip_x;
	} pose_req_t;

	typedef struct {
		logic [nad_pkg::ARC_W-1:0] arc;
		logic                      unreachable;
	} arc_res_t;

	// directed rows: typed expectation only where it is obvious
	typedef struct {
		pose_req_t                 req;
		bit                        typed;
		logic [nad_pkg::ARC_W-1:0] arc;
		logic                      unreachable;
	} stim_row_t;

	logic                         clk = 0;
	logic                         arst_n = 0;
	logic                         cfg_wr_en = 0;
	logic [31:0]                  cfg_wr_data = '0;
	logic                         s_axis_tvalid = 0;
	logic                         s_axis_tready;
	logic [nad_pkg::IN_W-1:0]     s_axis_tdata = '0;
	logic                         m_axis_tvalid;
	logic                         m_axis_tready = 0;
	logic [nad_pkg::ARC_W-1:0]    m_axis_tdata;
	logic                         m_axis_tuser;

	logic [31:0]       min_radius_q = '0;     // predictor copy of the register
	arc_res_t          arc_expected[$];       // predicted results in request order
	arc_res_t          arc_typed[$];          // hand-typed values for directed rows
	bit                typed_flag[$];
	stim_row_t         stim_rows[$];
	int                mismatches = 0;
	int                requests_sent = 0;
	int                results_seen = 0;
	int                unreach_seen = 0;
	int                saturated_seen = 0;
	int                cycle_count = 0;
	bit                calm = 0;              // no idling on either side
	int                sink_stall = 0;

	needle_arc_distance dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),    // tip_x .. frame_z, quat_w .. quat_k
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),    // arc_length
		.m_axis_tuser  (m_axis_tuser)     // unreachable
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// cycle counter doubles as the run watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				arc_expected.size());
			$display("testbench: errors");
			$finish;
		end
	end

	// round half away from zero, dropping s fraction bits
	function automatic longint round_away(input longint v, input int s);
		longint half;
		half = longint'(1) <<< (s - 1);
		if (v >= 0)
			return (v + half) >>> s;
		return -((-v + half) >>> s);
	endfunction

	// arc distance of one request under the given minimum radius
	function automatic arc_res_t arc_of_pose(input pose_req_t r, input logic [31:0] minr);
		arc_res_t          res;
		longint            d[3];
		longint            q[4];
		longint            rm[3][3];
		longint            p[3];
		longint            one;
		longint            xv;
		longint            yv;
		longint            dx;
		longint            dy;
		longint            acc;
		longint            step;
		logic [63:0]       a;
		logic [63:0]       b;
		logic [63:0]       c;
		logic [63:0]       sq;
		logic [63:0]       root;
		logic [63:0]       bitv;
		logic [63:0]       rq;
		logic [63:0]       thr;
		logic [63:0]       theta;
		logic [63:0]       prod;
		logic [127:0]      wide;
		int                k;
		d[0] = longint'(r.tip_x) - longint'(r.frame_x);
		d[1] = longint'(r.tip_y) - longint'(r.frame_y);
		d[2] = longint'(r.tip_z) - longint'(r.frame_z);
		q[0] = longint'(r.quat_w);
		q[1] = longint'(r.quat_i);
		q[2] = longint'(r.quat_j);
		q[3] = longint'(r.quat_k);
		one = longint'(1) <<< (2 * FB);
		rm[0][0] = one - 2 * (q[2] * q[2] + q[3] * q[3]);
		rm[0][1] = 2 * (q[1] * q[2] - q[0] * q[3]);
		rm[0][2] = 2 * (q[1] * q[3] + q[0] * q[2]);
		rm[1][0] = 2 * (q[1] * q[2] + q[0] * q[3]);
		rm[1][1] = one - 2 * (q[1] * q[1] + q[3] * q[3]);
		rm[1][2] = 2 * (q[2] * q[3] - q[0] * q[1]);
		rm[2][0] = 2 * (q[1] * q[3] - q[0] * q[2]);
		rm[2][1] = 2 * (q[2] * q[3] + q[0] * q[1]);
		rm[2][2] = one - 2 * (q[1] * q[1] + q[2] * q[2]);
		// p = R^T d, matrix entries rounded first
		for (int i = 0; i < 3; i++)
			p[i] = round_away(round_away(rm[0][i], FB) * d[0] +
				round_away(rm[1][i], FB) * d[1] + round_away(rm[2][i], FB) * d[2], FB);
		res.arc = '0;
		res.unreachable = 1'b0;
		if (p[2] < 0) begin
			res.unreachable = 1'b1;
			return res;
		end
		a = (p[0] < 0) ? -p[0] : p[0];
		b = (p[1] < 0) ? -p[1] : p[1];
		c = p[2];
		k = 0;
		while (((a >> k) | (b >> k) | (c >> k)) >= 64'h8000_0000)
			k++;
		a = a >> k;
		b = b >> k;
		// bitwise integer square root
		sq = a * a + b * b;
		root = '0;
		bitv = 64'h1 << 62;
		while (bitv > sq)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (sq >= root + bitv) begin
				sq = sq - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		// no lateral offset: straight ahead
		if (root == 0) begin
			res.arc = (c > {24'h0, nad_pkg::ARC_MAX}) ? nad_pkg::ARC_MAX :
				c[nad_pkg::ARC_W-1:0];
			return res;
		end
		c = c >> k;
		rq = (root * root + c * c) / (2 * root);
		thr = ({32'h0, minr} + (64'h1 << k) - 1) >> k;
		if (rq < thr) begin
			res.unreachable = 1'b1;
			return res;
		end
		// vectoring cordic for atan2(x, z) in q.30
		yv = root;
		xv = c;
		acc = 0;
		for (int i = 0; i < nad_pkg::CORDIC_STEPS; i++) begin
			dx = yv >>> i;
			dy = xv >>> i;
			step = (i < 11) ? longint'(nad_pkg::atan_step(i)) : (longint'(1) <<< (30 - i));
			if (yv > 0) begin
				xv = xv + dx;
				yv = yv - dy;
				acc = acc + step;
			end else begin
				xv = xv - dx;
				yv = yv + dy;
				acc = acc - step;
			end
		end
		if (acc < 0)
			acc = 0;
		theta = 2 * acc;
		wide = {64'h0, rq} * {64'h0, theta};
		prod = wide[93:30];
		if ((|wide[127:94]) || prod > ({24'h0, nad_pkg::ARC_MAX} >> k))
			res.arc = nad_pkg::ARC_MAX;
		else
			res.arc = nad_pkg::ARC_W'(prod << k);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [nad_pkg::ARC_W-1:0] got,
		input logic [nad_pkg::ARC_W-1:0] want);
		mismatches++;
		$display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
	endtask

	// request monitor: predict on every accepted request
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			arc_expected.push_back(arc_of_pose(pose_req_t'(s_axis_tdata), min_radius_q));
	end

	// result monitor
	always @(posedge clk) begin
		arc_res_t want;
		arc_res_t typed_want;
		bit       typed;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (m_axis_tuser)
				unreach_seen++;
			if (m_axis_tdata == nad_pkg::ARC_MAX)
				saturated_seen++;
			if (arc_expected.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata, '0);
			end else begin
				want = arc_expected.pop_front();
				if (m_axis_tdata !== want.arc)
					report_mismatch("arc_length", m_axis_tdata, want.arc);
				if (m_axis_tuser !== want.unreachable)
					report_mismatch("unreachable", m_axis_tuser, want.unreachable);
			end
			// directed rows also carry a hand-typed value
			if (typed_flag.size() != 0) begin
				typed = typed_flag.pop_front();
				typed_want = arc_typed.pop_front();
				if (typed && (m_axis_tdata !== typed_want.arc ||
					m_axis_tuser !== typed_want.unreachable))
					report_mismatch("typed value",
						{m_axis_tuser, m_axis_tdata[nad_pkg::ARC_W-2:0]},
						{typed_want.unreachable, typed_want.arc[nad_pkg::ARC_W-2:0]});
			end
		end
	end

	// result side backpressure in random bursts
	always @(posedge clk) begin
		if (calm) begin
			m_axis_tready <= 1'b1;
		end else if (sink_stall > 0) begin
			sink_stall <= sink_stall - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			sink_stall <= $urandom_range(0, 3);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// send one request and hold it until taken, then maybe idle
	task automatic send_request(input pose_req_t r);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= r;
		do
			@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready));
		requests_sent++;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 4);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drain the pipe, then write the register
	task automatic write_min_radius(input logic [31:0] v);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (arc_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		min_radius_q = v;
		@(posedge clk);
	endtask

	function automatic pose_req_t noise_pose();
		pose_req_t r;
		r = pose_req_t'(nad_pkg::IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom}));
		return r;
	endfunction

	// near-unit quaternion and a tip within a moderate reach of the frame
	function automatic pose_req_t planner_pose();
		pose_req_t r;
		real       qv[4];
		real       norm;
		int        reach;
		norm = 0.0;
		for (int i = 0; i < 4; i++) begin
			qv[i] = real'($urandom_range(0, 2000)) - 1000.0;
			norm = norm + qv[i] * qv[i];
		end
		if (norm < 1.0) begin
			qv[0] = 1.0;
			norm = 1.0;
		end
		norm = $sqrt(norm);
		r.quat_w = nad_pkg::QUAT_W'($rtoi(qv[0] / norm * 65536.0));
		r.quat_i = nad_pkg::QUAT_W'($rtoi(qv[1] / norm * 65536.0));
		r.quat_j = nad_pkg::QUAT_W'($rtoi(qv[2] / norm * 65536.0));
		r.quat_k = nad_pkg::QUAT_W'($rtoi(qv[3] / norm * 65536.0));
		r.frame_x = $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
		r.frame_y = $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
		r.frame_z = $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
		// mostly within 32 units, sometimes within 4 lsbs, sometimes far away (1024 units)
		case ($urandom_range(0, 5))
			0:       reach = 4;
			1:       reach = 32'h0400_0000;
			default: reach = 32'h0020_0000;
		endcase
		r.tip_x = r.frame_x + $signed($urandom_range(0, 2 * reach)) - reach;
		r.tip_y = r.frame_y + $signed($urandom_range(0, 2 * reach)) - reach;
		r.tip_z = r.frame_z + $signed($urandom_range(0, 2 * reach)) - reach;
		return r;
	endfunction

	function automatic pose_req_t pose_of(input int tx, input int ty, input int tz,
		input int fx, input int fy, input int fz, input int qw, input int qi,
		input int qj, input int qk);
		pose_req_t r;
		r.tip_x = tx;
		r.tip_y = ty;
		r.tip_z = tz;
		r.frame_x = fx;
		r.frame_y = fy;
		r.frame_z = fz;
		r.quat_w = nad_pkg::QUAT_W'(qw);
		r.quat_i = nad_pkg::QUAT_W'(qi);
		r.quat_j = nad_pkg::QUAT_W'(qj);
		r.quat_k = nad_pkg::QUAT_W'(qk);
		return r;
	endfunction

	task automatic add_row(input pose_req_t r, input bit typed,
		input logic [nad_pkg::ARC_W-1:0] arc, input logic unr);
		stim_row_t row;
		row.req = r;
		row.typed = typed;
		row.arc = arc;
		row.unreachable = unr;
		stim_rows.push_back(row);
	endtask

	initial begin
		arc_res_t tv;
		int       lo_min;
		int       hi_min;
		int       q_one;
		int       q_max;
		int       q_min;
		int       c_max;
		int       c_min;
		q_one = 65536;
		q_max = 131071;
		q_min = -131072;
		c_max = 32'h7fff_ffff;
		c_min = 32'h8000_0000;

		// identity frame: tip on the origin, straight ahead, behind, far ahead
		add_row(pose_of(0, 0, 0, 0, 0, 0, q_one, 0, 0, 0), 1, '0, 1'b0);
		add_row(pose_of(0, 0, 5 << 16, 0, 0, 0, q_one, 0, 0, 0), 1, 40'd5 << 16, 1'b0);
		add_row(pose_of(0, 0, -65536, 0, 0, 0, q_one, 0, 0, 0), 1, '0, 1'b1);
		add_row(pose_of(0, 0, c_max, 0, 0, c_min, q_one, 0, 0, 0), 1, 40'hFFFF_FFFF, 1'b0);
		// sideways offsets, tiny and huge
		add_row(pose_of(3 << 16, 0, 4 << 16, 0, 0, 0, q_one, 0, 0, 0), 0, '0, 1'b0);
		add_row(pose_of(0, 1, 1, 0, 0, 0, q_one, 0, 0, 0), 0, '0, 1'b0);
		add_row(pose_of(c_max, c_min, c_max, c_min, c_max, c_min, q_one, 0, 0, 0), 0, '0, 1'b0);
		add_row(pose_of(1, 0, c_max, 0, 0, c_min, q_one, 0, 0, 0), 0, '0, 1'b0);
		add_row(pose_of(c_max, c_max, 1, c_min, c_min, 0, q_one, 0, 0, 0), 0, '0, 1'b0);
		// quaternion extremes, unnormalized
		add_row(pose_of(c_max, c_max, c_max, c_min, c_min, c_min, q_max, q_max, q_max, q_max),
			0, '0, 1'b0);
		add_row(pose_of(c_min, c_min, c_min, c_max, c_max, c_max, q_min, q_min, q_min, q_min),
			0, '0, 1'b0);
		add_row(pose_of(c_max, 0, c_max, c_min, 0, c_min, 0, q_min, 0, 0), 0, '0, 1'b0);
		add_row(pose_of(0, c_max, c_max, 0, c_min, c_min, 0, 0, q_max, 0), 0, '0, 1'b0);
		add_row(pose_of(7 << 16, 2 << 16, 9 << 16, 0, 0, 0, 0, 0, 0, q_min), 0, '0, 1'b0);
		add_row(pose_of(1 << 16, 1 << 16, 1 << 16, 0, 0, 0, 0, 0, 0, 0), 0, '0, 1'b0);
		add_row(pose_of(-1, -1, c_max, 0, 0, 0, 46341, 46341, 0, 0), 0, '0, 1'b0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part with min_radius at reset value
		foreach (stim_rows[i]) begin
			tv.arc = stim_rows[i].arc;
			tv.unreachable = stim_rows[i].unreachable;
			arc_typed.push_back(tv);
			typed_flag.push_back(stim_rows[i].typed);
			send_request(stim_rows[i].req);
		end
		// a small radius floor rejects the sharp arcs
		write_min_radius(32'd3 << 16);
		add_row(pose_of(1 << 16, 0, 1 << 16, 0, 0, 0, q_one, 0, 0, 0), 0, '0, 1'b0);
		add_row(pose_of(1 << 16, 0, 10 << 16, 0, 0, 0, q_one, 0, 0, 0), 0, '0, 1'b0);
		send_request(stim_rows[stim_rows.size() - 2].req);
		send_request(stim_rows[stim_rows.size() - 1].req);
		// the largest floor: only straight-ahead tips get through
		write_min_radius(32'hFFFF_FFFF);
		send_request(pose_of(0, 0, 9 << 16, 0, 0, 0, q_one, 0, 0, 0));
		send_request(pose_of(c_max, 0, c_max, c_min, 0, c_min, q_one, 0, 0, 0));
		send_request(pose_of(1 << 16, 0, 10 << 16, 0, 0, 0, q_one, 0, 0, 0));

		// random phases over several radius floors
		lo_min = 0;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0:       write_min_radius(32'd0);
				1:       write_min_radius($urandom_range(1 << 16, 64 << 16));
				2:       write_min_radius($urandom);
				default: write_min_radius(32'd1);
			endcase
			if (ph == 3)
				calm = 1;
			hi_min = RANDOM_ITEMS / 4;
			for (int n = 0; n < hi_min; n++)
				send_request(($urandom_range(0, 9) < 7) ? planner_pose() : noise_pose());
			lo_min = lo_min + hi_min;
		end
		s_axis_tvalid <= 1'b0;

		while (arc_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("covered %0d requests over seven radius floors, %0d results", requests_sent,
			results_seen);
		$display("unreachable %0d, saturated %0d, random %0d", unreach_seen, saturated_seen,
			lo_min);
		if (mismatches == 0 && arc_expected.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/nad_pkg.sv
rtl/nad_isqrt.sv
rtl/nad_div_atan.sv
rtl/needle_arc_distance.sv
tb/sv/testbench.sv
